// ===== design/tal_pkg.sv =====
// shared types, constants and segment table for the thermistor converter
`default_nettype none

package tal_pkg;

  // group size and accumulator widths
  localparam int unsigned SAMPLES  = 10;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CNT_W    = 7;

  // datapath widths
  localparam int unsigned NUM_W    = 25;
  localparam int unsigned DEN_W    = 18;
  localparam int unsigned R_W      = 24;
  localparam int unsigned MV_W     = 12;
  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned MUL_A_W  = 16;
  localparam int unsigned MUL_B_W  = 14;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_CW   = $clog2(NUM_W);

  // conversion constants
  localparam logic [MUL_B_W-1:0] FULL_MV   = 14'd3300;
  localparam logic [MUL_B_W-1:0] R_REF     = 14'd10000;
  localparam logic [MUL_B_W-1:0] T_SCALE   = 14'd1000;
  localparam logic [MV_W-1:0]    MV_MAX    = 12'd3299;
  localparam int unsigned        SPAN_SH   = 10;

  // one piecewise-linear segment: lo < r < hi
  typedef struct packed {
    logic [15:0]       lo;
    logic [15:0]       hi;
    logic [15:0]       origin;
    logic [DEN_W-1:0]  slope;
    logic [TEMP_W-1:0] base;
  } seg_t;

  localparam int unsigned SEG_COUNT = 7;

  localparam seg_t SEG_TABLE [SEG_COUNT] = '{
    '{16'd20310, 16'd33970, 16'd33970, 18'd136600, 10'd0},
    '{16'd12570, 16'd20311, 16'd20310, 18'd77400,  10'd100},
    '{16'd8034,  16'd12571, 16'd12570, 18'd45370,  10'd200},
    '{16'd5298,  16'd8035,  16'd8034,  18'd27370,  10'd300},
    '{16'd3586,  16'd5299,  16'd5298,  18'd17130,  10'd400},
    '{16'd2484,  16'd3587,  16'd3586,  18'd11030,  10'd500},
    '{16'd1756,  16'd2485,  16'd2484,  18'd7280,   10'd600}
  };

  // closed group handed from the accumulator to the sequencer
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } grp_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/tal_accum.sv =====
// sample accumulator that closes a group every SAMPLES items
`default_nettype none

module tal_accum
  import tal_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [ADC_W-1:0] sample_i,
  output grp_t                  grp_o
);

  logic [SUM_W-1:0] sum_q, sum_d, sum_next;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  grp_t             grp_q, grp_d;
  logic             close;

  // next sum and count, wrapping like the counters they model
  assign sum_next = sum_q + SUM_W'(sample_i);
  assign cnt_next = cnt_q + CNT_W'(1);
  assign close    = (32'(cnt_next) >= SAMPLES) || (cnt_next == '0);

  always_comb begin
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    grp_d.valid = 1'b0;
    grp_d.sum   = grp_q.sum;
    if (take_i) begin
      if (close) begin
        sum_d       = '0;
        cnt_d       = '0;
        grp_d.valid = 1'b1;
        grp_d.sum   = sum_next;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      grp_q.valid <= 1'b0;
      grp_q.sum   <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

`ifndef SYNTH
  // count never rests at or past the group size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) < SAMPLES) else $error("sample count out of range");
  // a closed group leaves the running sum cleared
  a_close_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q.valid |-> (sum_q == '0 || $past(take_i) == 1'b0 || cnt_q == '0))
    else $error("running sum not cleared on group close");
`endif

endmodule

`default_nettype wire

// ===== design/tal_div.sv =====
// restoring divider, one quotient bit per cycle through a shift register
`default_nettype none

module tal_div
  import tal_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  div_req_t  req_i,
  output div_rsp_t  rsp_o
);

  logic [NUM_W-1:0]  nq_q, nq_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic              fit;

  // shift one numerator bit into the partial remainder and try the divisor
  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_comb begin
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      nq_d   = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      nq_d  = {nq_q[NUM_W-2:0], fit};
      cnt_d = cnt_q + DIV_CW'(1);
      if (cnt_q == DIV_CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q;

`ifndef SYNTH
  // a result appears only at the end of a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a division");
  // busy and done never overlap
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
`endif

endmodule

`default_nettype wire

// ===== design/thermistor_average_linearize.sv =====
// top level: averaging, resistance and piecewise-linear temperature conversion
`default_nettype none

// Each input item carries one 10-bit ADC sample. Every SAMPLES-th item
// closes a group and yields one result item: the mean is scaled to
// millivolts, turned into a thermistor resistance and mapped through seven
// segments to tenths of a degree; in_range (tuser) is 0 and the temperature
// 0 when no segment matches. A closing item blocks the input while the group
// is converted: three passes through the bit-serial divider, each shifting
// out 25 quotient bits, one per cycle, and the sequencing states between
// them. On a miss the third pass and its start state are skipped. The input
// stays blocked longer while an earlier result still waits in the output
// register. A finished result waits in the output register while the next
// group is accumulated.
module thermistor_average_linearize
  import tal_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] adc_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [9:0] temp_tenths
  output logic             m_axis_tuser    // [0] in_range
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MEAN   = 4'd1;
  localparam logic [3:0] S_MV     = 4'd2;
  localparam logic [3:0] S_RMUL   = 4'd3;
  localparam logic [3:0] S_RSTART = 4'd4;
  localparam logic [3:0] S_RDIV   = 4'd5;
  localparam logic [3:0] S_SEG    = 4'd6;
  localparam logic [3:0] S_TSTART = 4'd7;
  localparam logic [3:0] S_TDIV   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]         state_q, state_d;
  grp_t               grp;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               take;

  logic [PROD_W-1:0]  mul_q, mul_d;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_en;
  logic [MV_W-1:0]    mv_q, mv_d;
  logic [PROD_W-SPAN_SH-1:0] mv_raw;
  logic [R_W-1:0]     r_q, r_d;
  logic [DEN_W-1:0]   slope_q, slope_d;
  logic [TEMP_W-1:0]  base_q, base_d;
  logic [TEMP_W-1:0]  t_q, t_d;
  logic               hit_q, hit_d;

  logic               seg_hit;
  logic [15:0]        seg_diff;
  logic [DEN_W-1:0]   seg_slope;
  logic [TEMP_W-1:0]  seg_base;

  logic               out_valid_q;
  logic [TEMP_W-1:0]  out_temp_q;
  logic               out_range_q;
  logic               out_load;

  // input side: samples flow only while the sequencer rests
  assign s_axis_tready = (state_q == S_IDLE) && !grp.valid;
  assign take          = s_axis_tvalid && s_axis_tready;

  tal_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .sample_i (s_axis_tdata[ADC_W-1:0]),
    .grp_o    (grp)
  );

  tal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // divider requests: mean, resistance, segment offset
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(grp.sum);
    div_req.den   = DEN_W'(SAMPLES);
    case (state_q)
      S_IDLE: begin
        div_req.start = grp.valid;
      end
      S_RSTART: begin
        div_req.start = 1'b1;
        div_req.num   = mul_q[NUM_W-1:0];
        div_req.den   = DEN_W'(FULL_MV[MV_W-1:0] - mv_q);
      end
      S_TSTART: begin
        div_req.start = 1'b1;
        div_req.num   = mul_q[NUM_W-1:0];
        div_req.den   = slope_q;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // segment search on the registered resistance, first match wins
  always_comb begin
    seg_hit   = 1'b0;
    seg_diff  = '0;
    seg_slope = SEG_TABLE[0].slope;
    seg_base  = '0;
    for (int i = SEG_COUNT - 1; i >= 0; i--) begin
      if (r_q > R_W'(SEG_TABLE[i].lo) && r_q < R_W'(SEG_TABLE[i].hi)) begin
        seg_hit   = 1'b1;
        seg_diff  = 16'(R_W'(SEG_TABLE[i].origin) - r_q);
        seg_slope = SEG_TABLE[i].slope;
        seg_base  = SEG_TABLE[i].base;
      end
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_MEAN: begin
        mul_en = div_rsp.done;
        mul_a  = div_rsp.quo[MUL_A_W-1:0];
        mul_b  = FULL_MV;
      end
      S_RMUL: begin
        mul_a = MUL_A_W'(mv_q);
        mul_b = R_REF;
      end
      S_SEG: begin
        mul_a = seg_diff;
        mul_b = T_SCALE;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_d  = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : mul_q;
  assign mv_raw = mul_q[PROD_W-1:SPAN_SH];

  // sequencer
  always_comb begin
    state_d  = state_q;
    mv_d     = mv_q;
    r_d      = r_q;
    slope_d  = slope_q;
    base_d   = base_q;
    t_d      = t_q;
    hit_d    = hit_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (grp.valid) state_d = S_MEAN;
      end
      S_MEAN: begin
        if (div_rsp.done) state_d = S_MV;
      end
      S_MV: begin
        mv_d    = (mv_raw > (PROD_W-SPAN_SH)'(MV_MAX)) ? MV_MAX : mv_raw[MV_W-1:0];
        state_d = S_RMUL;
      end
      S_RMUL: begin
        state_d = S_RSTART;
      end
      S_RSTART: begin
        state_d = S_RDIV;
      end
      S_RDIV: begin
        if (div_rsp.done) begin
          r_d     = div_rsp.quo[R_W-1:0];
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        hit_d   = seg_hit;
        slope_d = seg_slope;
        base_d  = seg_base;
        t_d     = '0;
        state_d = seg_hit ? S_TSTART : S_OUT;
      end
      S_TSTART: begin
        state_d = S_TDIV;
      end
      S_TDIV: begin
        if (div_rsp.done) begin
          t_d     = div_rsp.quo[TEMP_W-1:0] + base_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q   <= mul_d;
    mv_q    <= mv_d;
    r_q     <= r_d;
    slope_q <= slope_d;
    base_q  <= base_d;
    t_q     <= t_d;
    hit_q   <= hit_d;
    if (out_load) begin
      out_temp_q  <= t_q;
      out_range_q <= hit_q;
    end
  end

  // output item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(out_temp_q);
  assign m_axis_tuser  = out_range_q;

`ifndef SYNTH
  // an out-of-range result carries a zero temperature
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("out-of-range result with nonzero temperature");
  // a calibrated result stays within the table's span
  a_temp_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata <= 16'd700))
    else $error("temperature beyond calibrated span");
  // a closed group always finds the sequencer at rest
  a_grp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp.valid |-> (state_q == S_IDLE)) else $error("group closed while converting");
  // divider results arrive only where the sequencer waits for them
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_MEAN || state_q == S_RDIV || state_q == S_TDIV))
    else $error("divider result with no consumer");
`endif

endmodule

`default_nettype wire
